// ===== hw/rtl/hhf_pkg.sv =====
package hhf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int PROB_W = FRAC_BITS + 2;
  localparam int LOG_W = 40;
  localparam int LNV_W = 22;

  localparam logic [PROB_W-1:0] PROB_SAT = {PROB_W{1'b1}};
  localparam logic [FRAC_BITS:0] PROB_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [LNV_W-1:0] LN2_Q16 = LNV_W'(45426);

  localparam logic [6:0] NUM_STATES_RST = 7'd64;
  localparam logic [15:0] MISMATCH_RST = 16'd66;

  localparam logic [7:0] REG_NUM_STATES = 8'd0;
  localparam logic [7:0] REG_MISMATCH = 8'd1;

  typedef logic [15:0] ln_tab_t [256];

  function automatic ln_tab_t ln_tab_build();
    ln_tab_t t;
    real x;
    for (int i = 0; i < 256; i++) begin
      x = $ln(1.0 + real'(i) / 256.0) * 65536.0;
      t[i] = 16'($rtoi(x + 0.5));
    end
    return t;
  endfunction

  localparam ln_tab_t LN_TAB = ln_tab_build();

  typedef struct packed {
    logic        start;
    logic        first;
    logic        target;
    logic [63:0] panel;
    logic [6:0]  n;
    logic [15:0] f0;
    logic [31:0] f1;
    logic [16:0] q_one;
    logic [16:0] q_mis;
    logic [15:0] mis;
  } pass_cmd_t;

  typedef struct packed {
    logic              done;
    logic [PROB_W-1:0] sum;
  } pass_sts_t;

endpackage

// ===== hw/rtl/hhf_if.sv =====
interface hhf_in_if;
  logic        valid;
  logic        ready;
  logic        target_allele;
  logic [63:0] panel_alleles;
  logic [15:0] switch_prob;
  logic [15:0] stay_prob;
  logic        first_variant;
  modport source(output valid, target_allele, panel_alleles, switch_prob, stay_prob,
                 first_variant, input ready);
  modport sink(input valid, target_allele, panel_alleles, switch_prob, stay_prob,
               first_variant, output ready);
endinterface

interface hhf_out_if;
  logic               valid;
  logic               ready;
  logic [17:0]        scale_sum;
  logic signed [39:0] log_likelihood;
  modport source(output valid, scale_sum, log_likelihood, input ready);
  modport sink(input valid, scale_sum, log_likelihood, output ready);
endinterface

interface hhf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/hhf_div.sv =====
module hhf_div #(
  parameter int DW = 32,
  parameter int VW = 18
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic [DW-1:0] quotient
);
  localparam int CW = $clog2(DW + 1);

  logic          busy_r;
  logic [CW-1:0] cnt_r;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [VW-1:0] div_r;
  logic [VW:0]   rem_sh, diff;
  logic          ge;

  always_comb begin
    rem_sh = {rem_r, quo_r[DW-1]};
    diff = rem_sh - {1'b0, div_r};
    ge = (rem_sh >= {1'b0, div_r});
    quo_nxt = {quo_r[DW-2:0], ge};
    rem_nxt = ge ? diff[VW-1:0] : rem_sh[VW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r <= CW'(DW);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      busy_r <= (cnt_r != CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign busy = busy_r;
  assign quotient = quo_r;
endmodule

// ===== hw/rtl/hhf_alpha.sv =====
module hhf_alpha #(
  parameter int MAX_STATES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  hhf_pkg::pass_cmd_t cmd,
  output hhf_pkg::pass_sts_t sts
);
  import hhf_pkg::*;

  localparam int IW = (MAX_STATES > 1) ? $clog2(MAX_STATES) : 1;
  localparam int SW = PROB_W + 7;
  localparam logic [2*FRAC_BITS+1:0] LIM = {(2*FRAC_BITS+2){1'b1}};

  logic [PROB_W-1:0] mem [MAX_STATES];

  pass_cmd_t         cmd_r;
  logic              run_r;
  logic [6:0]        cnt_r;
  logic              s1_v_r, s2_v_r, s3_v_r, done_r;
  logic [IW-1:0]     s1_k_r, s2_k_r, s3_k_r;
  logic [PROB_W-1:0] rdata_r;
  logic [49:0]       s2_prod_r;
  logic [PROB_W-1:0] s3_a_r;
  logic [SW-1:0]     sum_r;
  logic              issue;

  logic [PROB_W-1:0] t_sat;
  logic [PROB_W:0]   t_add;
  logic [PROB_W-1:0] t_fin;
  logic              match;
  logic [FRAC_BITS:0] e_w;
  logic [PROB_W+FRAC_BITS:0] prod2;
  logic [PROB_W-1:0] a_nxt;

  assign issue = run_r && (cnt_r < cmd_r.n);

  always_comb begin
    t_sat = (s2_prod_r > 50'(LIM)) ? PROB_SAT : s2_prod_r[FRAC_BITS +: PROB_W];
    t_add = {1'b0, t_sat} + (PROB_W + 1)'(cmd_r.f0);
    t_fin = t_add[PROB_W] ? PROB_SAT : t_add[PROB_W-1:0];
    match = (cmd_r.panel[s2_k_r] == cmd_r.target);
    e_w = match ? PROB_ONE : {1'b0, cmd_r.mis};
    prod2 = t_fin * e_w;
    if (cmd_r.first) begin
      a_nxt = match ? PROB_W'(cmd_r.q_one) : PROB_W'(cmd_r.q_mis);
    end else begin
      a_nxt = prod2[FRAC_BITS +: PROB_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      if (cmd.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (issue) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (run_r && !s1_v_r && !s2_v_r && !s3_v_r) begin
        run_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cmd_r <= cmd;
      sum_r <= '0;
    end else if (s3_v_r) begin
      sum_r <= sum_r + SW'(s3_a_r);
    end
    if (issue) begin
      rdata_r <= mem[cnt_r[IW-1:0]];
      s1_k_r <= cnt_r[IW-1:0];
    end
    s2_prod_r <= rdata_r * cmd_r.f1;
    s2_k_r <= s1_k_r;
    s3_a_r <= a_nxt;
    s3_k_r <= s2_k_r;
    if (s3_v_r) begin
      mem[s3_k_r] <= s3_a_r;
    end
  end

  assign sts.done = done_r;
  assign sts.sum = (sum_r > SW'(PROB_SAT)) ? PROB_SAT : sum_r[PROB_W-1:0];
endmodule

// ===== hw/rtl/haplotype_hmm_forward_scaled_core.sv =====
// a variant request is accepted only in the idle state, so a new variant is not taken until
// the previous result has been loaded into the output register; two serial
// dividers run side by side, then one read-modify-write pass over the alpha memory
// reset: synchronous active-low rst_n clears control, prev sum and log-likelihood,
// num_states to 64, mismatch_ratio to 66; the alpha memory is not cleared
module haplotype_hmm_forward_scaled_core #(
  parameter int MAX_STATES = 64
) (
  input logic clk,
  input logic rst_n,
  hhf_in_if.sink    in_ch,
  hhf_out_if.source out_ch,
  hhf_cfg_if.sink   cfg_ch
);
  import hhf_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_PASS = 3'd2;
  localparam logic [2:0] ST_LOG  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]  state_r;
  logic [6:0]  num_states_r;
  logic [15:0] mismatch_r;
  logic        first_r, target_r;
  logic [63:0] panel_r;
  logic [6:0]  n_r, n_nxt;
  logic [PROB_W-1:0] prev_sum_r, sum_r;
  logic signed [LOG_W-1:0] loglik_r;
  logic signed [LNV_W-1:0] lnv_r, lnv_nxt;
  logic        div_start;
  logic [16:0] a_dvd;
  logic [31:0] b_dvd;
  logic [17:0] b_dvs;
  logic        a_busy, b_busy;
  logic [16:0] a_q;
  logic [31:0] b_q;
  logic        out_valid_r;
  logic [PROB_W-1:0] out_sum_r;
  logic signed [LOG_W-1:0] out_log_r;
  pass_cmd_t   cmd;
  pass_sts_t   sts;
  logic [4:0]  lead;
  logic [PROB_W-1:0] norm;
  logic signed [LOG_W-1:0] base;
  logic signed [LOG_W:0]   acc;
  logic signed [LOG_W-1:0] loglik_nxt;
  logic        accept;

  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    n_nxt = num_states_r;
    if (num_states_r == 7'd0) begin
      n_nxt = 7'd1;
    end else if (num_states_r > 7'(MAX_STATES)) begin
      n_nxt = 7'(MAX_STATES);
    end
  end

  assign div_start = (state_r == ST_IDLE) && accept;
  assign a_dvd = in_ch.first_variant ? PROB_ONE : {1'b0, in_ch.switch_prob};
  assign b_dvd = in_ch.first_variant ? {16'd0, mismatch_r} : {in_ch.stay_prob, 16'd0};
  assign b_dvs = in_ch.first_variant ? {11'd0, n_nxt} : prev_sum_r;

  hhf_div #(.DW(17), .VW(7)) u_div_a (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(a_dvd), .divisor(n_nxt),
    .busy(a_busy), .quotient(a_q)
  );

  hhf_div #(.DW(32), .VW(18)) u_div_b (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(b_dvd), .divisor(b_dvs),
    .busy(b_busy), .quotient(b_q)
  );

  always_comb begin
    cmd.start = (state_r == ST_DIV) && !a_busy && !b_busy;
    cmd.first = first_r;
    cmd.target = target_r;
    cmd.panel = panel_r;
    cmd.n = n_r;
    cmd.f0 = a_q[15:0];
    cmd.f1 = (prev_sum_r == '0) ? 32'd0 : b_q;
    cmd.q_one = a_q;
    cmd.q_mis = b_q[16:0];
    cmd.mis = mismatch_r;
  end

  hhf_alpha #(.MAX_STATES(MAX_STATES)) u_alpha (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts)
  );

  always_comb begin
    lead = '0;
    for (int i = 0; i < PROB_W; i++) begin
      if (sum_r[i]) begin
        lead = 5'(i);
      end
    end
    norm = sum_r << (5'(PROB_W - 1) - lead);
    lnv_nxt = (LNV_W'(lead) - LNV_W'(FRAC_BITS)) * $signed(LN2_Q16)
            + $signed({6'd0, LN_TAB[norm[PROB_W-2 -: 8]]});
  end

  always_comb begin
    base = first_r ? '0 : loglik_r;
    acc = {base[LOG_W-1], base} + (LOG_W + 1)'(lnv_r);
    if (sum_r == '0) begin
      loglik_nxt = {1'b1, {(LOG_W-1){1'b0}}};
    end else if (acc[LOG_W] != acc[LOG_W-1]) begin
      loglik_nxt = acc[LOG_W] ? {1'b1, {(LOG_W-1){1'b0}}} : {1'b0, {(LOG_W-1){1'b1}}};
    end else begin
      loglik_nxt = acc[LOG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      num_states_r <= NUM_STATES_RST;
      mismatch_r <= MISMATCH_RST;
      prev_sum_r <= '0;
      loglik_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_NUM_STATES: num_states_r <= cfg_ch.data[6:0];
          REG_MISMATCH:   mismatch_r <= cfg_ch.data;
          default:        ;
        endcase
      end
      if (out_valid_r && out_ch.ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (!a_busy && !b_busy) begin
            state_r <= ST_PASS;
          end
        end
        ST_PASS: begin
          if (sts.done) begin
            state_r <= ST_LOG;
          end
        end
        ST_LOG: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            prev_sum_r <= sum_r;
            loglik_r <= loglik_nxt;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      first_r <= in_ch.first_variant;
      target_r <= in_ch.target_allele;
      panel_r <= in_ch.panel_alleles;
      n_r <= n_nxt;
    end
    if (sts.done) begin
      sum_r <= sts.sum;
    end
    if (state_r == ST_LOG) begin
      lnv_r <= lnv_nxt;
    end
    if ((state_r == ST_FIN) && (!out_valid_r || out_ch.ready)) begin
      out_sum_r <= sum_r;
      out_log_r <= loglik_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.scale_sum = out_sum_r;
  assign out_ch.log_likelihood = out_log_r;
endmodule

// ===== dv/haplotype_hmm_forward_scaled_core_tb.sv =====
module haplotype_hmm_forward_scaled_core_tb;
  import hhf_pkg::*;

  typedef struct packed {
    logic [17:0]        sum;
    logic signed [39:0] loglik;
  } variant_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #2 clk = ~clk;

  hhf_in_if  in_ch ();
  hhf_out_if out_ch ();
  hhf_cfg_if cfg_ch ();

  haplotype_hmm_forward_scaled_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  // predictor state
  logic [17:0]        alpha_m [64];
  bit                 alpha_written [64];
  logic [17:0]        sum_m;
  logic signed [39:0] loglik_m;
  logic [6:0]         states_m;
  logic [15:0]        mis_m;
  logic [15:0]        ln_lut [256];

  variant_result_t expected_q [$];
  int errors;
  int results_seen;
  int requests_sent;
  bit pass_started;
  bit idle_in_en;
  bit idle_out_en;
  bit hold_out;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, results_seen);
    errors++;
  endtask

  function automatic void build_ln_lut();
    for (int i = 0; i < 256; i++)
      ln_lut[i] = 16'($rtoi($ln(1.0 + real'(i) / 256.0) * 65536.0 + 0.5));
  endfunction

  function automatic longint ln_q16(input logic [17:0] s);
    int p;
    int idx;
    p = 17;
    while (p > 0 && !s[p]) p--;
    if (p >= 8) idx = (s >> (p - 8)) & 255;
    else idx = (s << (8 - p)) & 255;
    return longint'(p - 16) * 45426 + longint'(ln_lut[idx]);
  endfunction

  function automatic variant_result_t predict_variant(input logic tgt, input logic [63:0] panel,
                                                      input logic [15:0] sw,
                                                      input logic [15:0] st,
                                                      input logic first);
    longint unsigned n, f0, f1, e, a, ap, t, sum;
    longint unsigned sat, lim;
    longint v;
    variant_result_t r;
    sat = 64'h3FFFF;
    lim = (64'd1 << 34) - 1;
    n = states_m;
    f0 = 0;
    f1 = 0;
    sum = 0;
    if (n < 1) n = 1;
    if (n > 64) n = 64;
    if (!first) begin
      f0 = sw / n;
      f1 = (sum_m != 0) ? ((longint'(st)) << 16) / sum_m : 0;
    end
    for (int k = 0; k < n; k++) begin
      e = (panel[k] == tgt) ? 64'h10000 : longint'(mis_m);
      if (first) begin
        a = e / n;
      end else begin
        ap = alpha_m[k];
        if (ap != 0 && f1 > lim / ap) t = sat;
        else t = (ap * f1) >> 16;
        t += f0;
        if (t > sat) t = sat;
        a = (t * e) >> 16;
      end
      alpha_m[k] = a[17:0];
      alpha_written[k] = 1'b1;
      sum += a;
    end
    if (sum > sat) sum = sat;
    sum_m = sum[17:0];
    if (sum == 0) begin
      loglik_m = {1'b1, 39'd0};
    end else begin
      v = (first ? 64'sd0 : longint'(loglik_m)) + ln_q16(sum[17:0]);
      if (v > 64'sd549755813887) v = 64'sd549755813887;
      if (v < -64'sd549755813888) v = -64'sd549755813888;
      loglik_m = v[39:0];
    end
    r.sum = sum_m;
    r.loglik = loglik_m;
    return r;
  endfunction

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_NUM_STATES) states_m = val[6:0];
    else if (idx == REG_MISMATCH) mis_m = val;
    @(posedge clk);
  endtask

  task automatic send_variant(input logic tgt, input logic [63:0] panel,
                              input logic [15:0] sw, input logic [15:0] st,
                              input logic first);
    int n;
    n = (states_m < 1) ? 1 : (states_m > 64 ? 64 : states_m);
    // never touch an alpha entry that was not written
    if (!first) begin
      for (int k = 0; k < n; k++)
        if (!alpha_written[k]) first = 1'b1;
      if (!pass_started) first = 1'b1;
    end
    while (idle_in_en && $urandom_range(99) < 8) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.target_allele <= tgt;
    in_ch.panel_alleles <= panel;
    in_ch.switch_prob   <= sw;
    in_ch.stay_prob     <= st;
    in_ch.first_variant <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(predict_variant(tgt, panel, sw, st, first));
    pass_started = 1'b1;
    requests_sent++;
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [63:0] rand_panel();
    return {$urandom(), $urandom()};
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      variant_result_t w;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_ch.scale_sum), 64'd0);
      end else begin
        w = expected_q.pop_front();
        if (out_ch.scale_sum !== w.sum)
          report_mismatch("scale_sum", 64'(out_ch.scale_sum), 64'(w.sum));
        if (out_ch.log_likelihood !== w.loglik)
          report_mismatch("log_likelihood", 64'(out_ch.log_likelihood), 64'(w.loglik));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (hold_out) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(idle_out_en && $urandom_range(99) < 8);
  end

  task automatic test_extremes();
    write_reg(REG_NUM_STATES, 16'd64);
    write_reg(REG_MISMATCH, 16'd66);
    send_variant(1'b0, 64'd0, 16'd0, 16'd0, 1'b1);
    send_variant(1'b1, 64'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    send_variant(1'b1, '1, 16'h0000, 16'hFFFF, 1'b0);
    send_variant(1'b0, 64'hAAAA_5555_F0F0_0F0F, 16'hFFFF, 16'h0000, 1'b0);
    send_variant(1'b1, 64'd0, 16'd1, 16'd1, 1'b1);
    drain();
    // zero mismatch weight with all-mismatch panels gives zero sums and the log floor
    write_reg(REG_MISMATCH, 16'd0);
    send_variant(1'b1, 64'd0, 16'd0, 16'd0, 1'b1);
    send_variant(1'b1, 64'd0, 16'd0, 16'hFFFF, 1'b0);
    send_variant(1'b0, 64'd0, 16'h8000, 16'h8000, 1'b0);
    drain();
    write_reg(REG_MISMATCH, 16'hFFFF);
    write_reg(REG_NUM_STATES, 16'd0);
    send_variant(1'b1, 64'd0, 16'h1234, 16'hFFFF, 1'b1);
    send_variant(1'b0, 64'd1, 16'hFFFF, 16'hFFFF, 1'b0);
    drain();
    write_reg(REG_NUM_STATES, 16'd127);
    send_variant(1'b0, '1, 16'd100, 16'hF000, 1'b1);
    send_variant(1'b1, rand_panel(), 16'd100, 16'hF000, 1'b0);
    drain();
    // a single mismatching state with the smallest nonzero weight, then a large stay term
    write_reg(REG_NUM_STATES, 16'd64);
    write_reg(REG_MISMATCH, 16'd1);
    send_variant(1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 16'd0, 16'd0, 1'b1);
    send_variant(1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 16'd0, 16'hFFFF, 1'b0);
    send_variant(1'b0, 64'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    drain();
    // shrink the state count with earlier entries kept
    write_reg(REG_NUM_STATES, 16'd8);
    send_variant(1'b0, rand_panel(), 16'h0800, 16'hF000, 1'b0);
    drain();
  endtask

  task automatic test_backpressure();
    write_reg(REG_NUM_STATES, 16'd4);
    write_reg(REG_MISMATCH, 16'd3000);
    hold_out = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_out = 1'b0;
      end
      for (int i = 0; i < 12; i++)
        send_variant(1'($urandom_range(1)), rand_panel(), 16'($urandom), 16'($urandom),
                     i == 0);
    join
    drain();
  endtask

  task automatic test_random_passes();
    int remaining;
    int len;
    remaining = 1000;
    while (remaining > 0) begin
      if ($urandom_range(3) == 0) begin
        drain();
        case ($urandom_range(4))
          0: write_reg(REG_NUM_STATES, 16'd1);
          1: write_reg(REG_NUM_STATES, 16'd64);
          default: write_reg(REG_NUM_STATES, 16'($urandom_range(1, 64)));
        endcase
        case ($urandom_range(3))
          0: write_reg(REG_MISMATCH, 16'hFFFF);
          1: write_reg(REG_MISMATCH, 16'd0);
          default: write_reg(REG_MISMATCH, 16'($urandom));
        endcase
      end
      idle_in_en = (remaining > 150);
      idle_out_en = (remaining > 150);
      len = $urandom_range(1, 40);
      for (int i = 0; i < len && remaining > 0; i++) begin
        send_variant(1'($urandom_range(1)), rand_panel(),
                     $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(4000)),
                     $urandom_range(9) == 0 ? 16'($urandom) : 16'($urandom_range(40000, 65535)),
                     i == 0 || $urandom_range(49) == 0);
        remaining--;
      end
      if ($urandom_range(5) == 0) while (expected_q.size() != 0) @(posedge clk);
    end
    idle_in_en = 1'b1;
    idle_out_en = 1'b1;
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.target_allele = 1'b0;
    in_ch.panel_alleles = '0;
    in_ch.switch_prob = '0;
    in_ch.stay_prob = '0;
    in_ch.first_variant = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    out_ch.ready = 1'b0;
    hold_out = 1'b0;
    idle_in_en = 1'b1;
    idle_out_en = 1'b1;
    errors = 0;
    results_seen = 0;
    requests_sent = 0;
    pass_started = 1'b0;
    sum_m = '0;
    loglik_m = '0;
    states_m = NUM_STATES_RST;
    mis_m = MISMATCH_RST;
    foreach (alpha_written[k]) alpha_written[k] = 1'b0;
    build_ln_lut();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_extremes();
    test_backpressure();
    test_random_passes();
    $display("covered %0d variant requests, %0d results, state counts 0..127, mismatch 0..ffff",
             requests_sent, results_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("CHECK FAILED");
    $finish;
  end

endmodule
